>>> sv/fifo_queue_with_key_search_top_macros.svh
// ---------------------------------------------------------------------------
// fifo queue with key search: assertion macros
// shared property forms for the checks in the rtl modules
// ---------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_KEY_SEARCH_TOP_MACROS_SVH
`define FIFO_QUEUE_WITH_KEY_SEARCH_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FQKS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqks check failed");

// next-cycle implication, sampled on clk, off during reset
`define FQKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqks check failed");

`endif

>>> sv/fqks_pkg.sv
// ---------------------------------------------------------------------------
// fqks_pkg
// shared sizes, request codes and interface structs of the key search queue
// ---------------------------------------------------------------------------
package fqks_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW    = 32;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [KW-1:0] wdata;
        logic [AW-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                 ok;
        logic signed [KW-1:0] key_out;
        logic [AW-1:0]        position;
        logic [CW-1:0]        entry_count;
        logic signed [KW-1:0] head_key;
        logic signed [KW-1:0] tail_key;
        logic                 is_empty;
    } res_t;

    // ring index plus offset, offset below DEPTH
    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] offs);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(offs);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

>>> sv/fqks_store.sv
// ---------------------------------------------------------------------------
// fqks_store
// key ring memory, one write port and one registered read port
// ---------------------------------------------------------------------------
module fqks_store (
    input  logic                        clk,
    input  fqks_pkg::mem_req_t          mreq,
    output logic [fqks_pkg::KW-1:0]     rdata
);

    logic [fqks_pkg::KW-1:0] mem [fqks_pkg::DEPTH];
    logic [fqks_pkg::KW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
        rdata_reg <= mem[mreq.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fqks_ctrl.sv
// ---------------------------------------------------------------------------
// fqks_ctrl
// request sequencer: ring pointers, cached end keys and the search walk
// ---------------------------------------------------------------------------
`include "fifo_queue_with_key_search_top_macros.svh"

module fqks_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [1:0]                      req_kind,
    input  logic signed [fqks_pkg::KW-1:0]  req_key,
    input  logic                            out_busy,
    output fqks_pkg::mem_req_t              mreq,
    input  logic [fqks_pkg::KW-1:0]         rdata,
    output logic                            res_valid,
    output fqks_pkg::res_t                  res
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_POP_RD = 4'b0010,
        ST_POP_WB = 4'b0100,
        ST_SRCH   = 4'b1000
    } state_t;

    state_t                      st_reg, st_next;
    logic [fqks_pkg::AW-1:0]     head_reg, head_next;
    logic [fqks_pkg::AW-1:0]     tail_reg, tail_next;
    logic [fqks_pkg::CW-1:0]     count_reg, count_next;
    logic [fqks_pkg::KW-1:0]     head_key_reg, head_key_next;
    logic [fqks_pkg::KW-1:0]     tail_key_reg, tail_key_next;
    logic [fqks_pkg::KW-1:0]     key_reg, key_next;
    logic [fqks_pkg::CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [fqks_pkg::AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                        cmp_vld_reg, cmp_vld_next;
    logic                        req_fire;

    function automatic fqks_pkg::res_t mk_res(
        logic                    ok,
        logic [fqks_pkg::KW-1:0] kout,
        logic [fqks_pkg::AW-1:0] pos,
        logic [fqks_pkg::CW-1:0] cnt,
        logic [fqks_pkg::KW-1:0] hk,
        logic [fqks_pkg::KW-1:0] tk
    );
        fqks_pkg::res_t r;
        r.ok          = ok;
        r.key_out     = kout;
        r.position    = pos;
        r.entry_count = cnt;
        r.is_empty    = (cnt == '0);
        r.head_key    = r.is_empty ? '0 : hk;
        r.tail_key    = r.is_empty ? '0 : tk;
        return r;
    endfunction

    assign req_ready = (st_reg == ST_IDLE) && !out_busy;
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        st_next       = st_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        head_key_next = head_key_reg;
        tail_key_next = tail_key_reg;
        key_next      = key_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        cmp_vld_next  = cmp_vld_reg;

        mreq.we    = 1'b0;
        mreq.waddr = tail_reg;
        mreq.wdata = req_key;
        mreq.raddr = fqks_pkg::ring_add(head_reg, rd_idx_reg);

        res_valid = 1'b0;
        res = mk_res(1'b0, '0, '0, count_reg, head_key_reg, tail_key_reg);

        unique case (st_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (fqks_pkg::op_t'(req_kind))
                        fqks_pkg::OP_PUSH:
                        begin
                            res_valid = 1'b1;
                            if (count_reg != fqks_pkg::CW'(fqks_pkg::DEPTH))
                            begin
                                mreq.we       = 1'b1;
                                tail_next     = fqks_pkg::ring_add(tail_reg,
                                                                   fqks_pkg::CW'(1));
                                count_next    = count_reg + fqks_pkg::CW'(1);
                                tail_key_next = req_key;
                                if (count_reg == '0)
                                begin
                                    head_key_next = req_key;
                                end
                                res = mk_res(1'b1, '0, '0, count_next,
                                             head_key_next, tail_key_next);
                            end
                        end
                        fqks_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                head_next  = fqks_pkg::ring_add(head_reg, fqks_pkg::CW'(1));
                                count_next = count_reg - fqks_pkg::CW'(1);
                                // popped key is parked in key_reg until the new head is read
                                key_next   = head_key_reg;
                                if (count_reg == fqks_pkg::CW'(1))
                                begin
                                    res_valid = 1'b1;
                                    res = mk_res(1'b1, head_key_reg, '0, count_next,
                                                 head_key_reg, tail_key_reg);
                                end
                                else
                                begin
                                    st_next = ST_POP_RD;
                                end
                            end
                        end
                        fqks_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                key_next     = req_key;
                                rd_idx_next  = '0;
                                cmp_vld_next = 1'b0;
                                st_next      = ST_SRCH;
                            end
                        end
                        fqks_pkg::OP_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                            res_valid  = 1'b1;
                            res = mk_res(1'b1, '0, '0, '0, head_key_reg, tail_key_reg);
                        end
                    endcase
                end
            end
            ST_POP_RD:
            begin
                mreq.raddr = head_reg;
                st_next    = ST_POP_WB;
            end
            ST_POP_WB:
            begin
                head_key_next = rdata;
                res_valid     = 1'b1;
                res = mk_res(1'b1, key_reg, '0, count_reg, rdata, tail_key_reg);
                st_next       = ST_IDLE;
            end
            ST_SRCH:
            begin
                // compare the entry read last cycle while the next read goes out
                if (cmp_vld_reg && (rdata == key_reg))
                begin
                    res_valid = 1'b1;
                    res = mk_res(1'b1, '0, cmp_idx_reg, count_reg,
                                 head_key_reg, tail_key_reg);
                    st_next   = ST_IDLE;
                end
                else if (cmp_vld_reg &&
                         (fqks_pkg::CW'(cmp_idx_reg) + fqks_pkg::CW'(1) == count_reg))
                begin
                    res_valid = 1'b1;
                    st_next   = ST_IDLE;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[fqks_pkg::AW-1:0];
                    rd_idx_next  = rd_idx_reg + fqks_pkg::CW'(1);
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_key_reg <= head_key_next;
        tail_key_reg <= tail_key_next;
        key_reg      <= key_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
    end

    `FQKS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= fqks_pkg::CW'(fqks_pkg::DEPTH))
    `FQKS_ASSERT_NEXT(a_res_to_idle, res_valid, st_reg == ST_IDLE)
    `FQKS_ASSERT_NOW(a_walk_nonempty, st_reg == ST_SRCH, count_reg != '0)
    `FQKS_ASSERT_NOW(a_ring_span, count_reg == '0, head_reg == tail_reg)

endmodule

>>> sv/fifo_queue_with_key_search_top.sv
// ---------------------------------------------------------------------------
// fifo_queue_with_key_search_top: 16-entry key queue with search
// push, clear, failed pop, pop of the last entry and empty search answer from idle;
// other pops read the new head first; search does one ring read and compare per entry
// one request at a time; the next is taken once the result has left
// rst_n clears the queue and the sequencer asynchronously; ring contents kept
// ---------------------------------------------------------------------------
`include "fifo_queue_with_key_search_top_macros.svh"

module fifo_queue_with_key_search_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      kind,
    input  logic signed [fqks_pkg::KW-1:0]  key_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            ok,
    output logic signed [fqks_pkg::KW-1:0]  key_out,
    output logic [fqks_pkg::AW-1:0]         position,
    output logic [fqks_pkg::CW-1:0]         entry_count,
    output logic signed [fqks_pkg::KW-1:0]  head_key,
    output logic signed [fqks_pkg::KW-1:0]  tail_key,
    output logic                            is_empty
);

    fqks_pkg::mem_req_t          mreq;
    logic [fqks_pkg::KW-1:0]     rdata;
    logic                        res_valid;
    fqks_pkg::res_t              res;
    logic                        out_valid_reg, out_valid_next;
    fqks_pkg::res_t              out_reg, out_next;

    fqks_store u_store (
        .clk   (clk),
        .mreq  (mreq),
        .rdata (rdata)
    );

    fqks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req_kind  (kind),
        .req_key   (key_in),
        .out_busy  (out_valid_reg),
        .mreq      (mreq),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign ok          = out_reg.ok;
    assign key_out     = out_reg.key_out;
    assign position    = out_reg.position;
    assign entry_count = out_reg.entry_count;
    assign head_key    = out_reg.head_key;
    assign tail_key    = out_reg.tail_key;
    assign is_empty    = out_reg.is_empty;

    `FQKS_ASSERT_NOW(a_no_overwrite, res_valid, !out_valid_reg)
    `FQKS_ASSERT_NOW(a_busy_no_take, out_valid_reg, !in_ready)

endmodule

>>> dv/fqks_status_checker.sv
// ---------------------------------------------------------------------------
// fqks_status_checker: request/status scoreboard for the key search queue
// keeps its own ring of keys, predicts the status of every accepted request
// and compares each returned status field by field, oldest first
// ---------------------------------------------------------------------------
module fqks_status_checker
    import fqks_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic signed [KW-1:0] key_in,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 ok,
    input  logic signed [KW-1:0] key_out,
    input  logic [AW-1:0]        position,
    input  logic [CW-1:0]        entry_count,
    input  logic signed [KW-1:0] head_key,
    input  logic signed [KW-1:0] tail_key,
    input  logic                 is_empty,
    output int                   mismatches,
    output int                   outstanding
);

    logic [KW-1:0] ring [DEPTH];
    logic [AW-1:0] head_idx;
    logic [AW-1:0] tail_idx;
    logic [CW-1:0] fill;
    res_t          status_due [$];
    res_t          want;

    function automatic logic [AW-1:0] step_index(logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // applies one request to the local ring and returns the status it yields
    function automatic res_t predict_status(op_t op, logic [KW-1:0] key);
        res_t          r;
        logic [AW-1:0] idx;
        logic          found;
        r     = '0;
        found = 1'b0;
        case (op)
            OP_PUSH:
            begin
                if (fill < CW'(DEPTH))
                begin
                    ring[tail_idx] = key;
                    tail_idx       = step_index(tail_idx);
                    fill           = fill + 1'b1;
                    r.ok           = 1'b1;
                end
            end
            OP_POP:
            begin
                if (fill != '0)
                begin
                    r.key_out = ring[head_idx];
                    head_idx  = step_index(head_idx);
                    fill      = fill - 1'b1;
                    r.ok      = 1'b1;
                end
            end
            OP_SEARCH:
            begin
                idx = head_idx;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (i < fill && !found && ring[idx] == key)
                    begin
                        found      = 1'b1;
                        r.ok       = 1'b1;
                        r.position = AW'(i);
                    end
                    idx = step_index(idx);
                end
            end
            default:
            begin
                head_idx = '0;
                tail_idx = '0;
                fill     = '0;
                r.ok     = 1'b1;
            end
        endcase
        r.entry_count = fill;
        r.is_empty    = (fill == '0);
        if (fill != '0)
        begin
            r.head_key = ring[head_idx];
            r.tail_key = ring[(tail_idx == '0) ? AW'(DEPTH - 1) : tail_idx - 1'b1];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [KW-1:0] got, logic [KW-1:0] exp_val);
        $display("mismatch %s: got %08h expected %08h at %0t", what, got, exp_val, $time);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx = '0;
            tail_idx = '0;
            fill     = '0;
            foreach (ring[k])
            begin
                ring[k] = '0;
            end
            status_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                status_due.push_back(predict_status(op_t'(kind), key_in));
            end
            if (out_valid && out_ready)
            begin
                if (status_due.size() == 0)
                begin
                    report_mismatch("unrequested status", {31'b0, ok}, '0);
                end
                else
                begin
                    want = status_due.pop_front();
                    if (ok !== want.ok)
                        report_mismatch("ok", KW'(ok), KW'(want.ok));
                    if (key_out !== want.key_out)
                        report_mismatch("key_out", key_out, want.key_out);
                    if (position !== want.position)
                        report_mismatch("position", KW'(position), KW'(want.position));
                    if (entry_count !== want.entry_count)
                        report_mismatch("entry_count", KW'(entry_count), KW'(want.entry_count));
                    if (head_key !== want.head_key)
                        report_mismatch("head_key", head_key, want.head_key);
                    if (tail_key !== want.tail_key)
                        report_mismatch("tail_key", tail_key, want.tail_key);
                    if (is_empty !== want.is_empty)
                        report_mismatch("is_empty", KW'(is_empty), KW'(want.is_empty));
                end
            end
            outstanding = status_due.size();
        end
    end

endmodule

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for the key search queue
// directed requests cover empty pops and searches, signed key extremes,
// duplicate keys, a full queue and clear; random phases follow with fill and
// drain biased traffic, varied idling and a long receiver hold-off
// ---------------------------------------------------------------------------
module tb_top;
    import fqks_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 out_ready = 1'b0;
    logic                 hold_off  = 1'b0;
    logic [1:0]           kind      = OP_PUSH;
    logic signed [KW-1:0] key_in    = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 ok;
    logic signed [KW-1:0] key_out;
    logic [AW-1:0]        position;
    logic [CW-1:0]        entry_count;
    logic signed [KW-1:0] head_key;
    logic signed [KW-1:0] tail_key;
    logic                 is_empty;
    int                   mismatches;
    int                   outstanding;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   cycle_count    = 0;
    logic [KW-1:0]        key_pool [6];

    always #5 clk = ~clk;

    fifo_queue_with_key_search_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key_in      (key_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .key_out     (key_out),
        .position    (position),
        .entry_count (entry_count),
        .head_key    (head_key),
        .tail_key    (tail_key),
        .is_empty    (is_empty)
    );

    fqks_status_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key_in      (key_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .key_out     (key_out),
        .position    (position),
        .entry_count (entry_count),
        .head_key    (head_key),
        .tail_key    (tail_key),
        .is_empty    (is_empty),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[fifo_queue_with_key_search_top] ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready = !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(input op_t op, input logic [KW-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
        end
        in_valid = 1'b1;
        kind     = op;
        key_in   = key;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic hold_receiver(input int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(negedge clk);
        hold_off = 1'b0;
    endtask

    task automatic wait_drained();
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    // mostly keys from a small pool so that searches hit and duplicates occur
    function automatic logic [KW-1:0] pick_key();
        return ($urandom_range(99) < 70) ? key_pool[$urandom_range(5)] : $urandom();
    endfunction

    // alternating fill and drain stretches so the queue swings between empty and full
    task automatic run_random(input int count);
        int   roll;
        logic fill_phase;
        for (int i = 0; i < count; i++)
        begin
            fill_phase = ((i / 24) % 2) == 0;
            roll       = $urandom_range(99);
            if (roll >= 98)
                send_request(OP_CLEAR, $urandom());
            else if (roll >= 75)
                send_request(OP_SEARCH, pick_key());
            else if ((roll < 60) == fill_phase)
                send_request(OP_PUSH, pick_key());
            else
                send_request(OP_POP, $urandom());
        end
    endtask

    initial
    begin
        foreach (key_pool[k])
        begin
            key_pool[k] = $urandom();
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty cases, key extremes, duplicates, full queue, clear
        send_request(OP_POP, 32'h0000_0000);
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_PUSH, 32'h7fff_ffff);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'hffff_ffff);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_SEARCH, 32'h8000_0000);
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_POP, 32'hffff_ffff);
        for (int k = 0; k < 13; k++)
        begin
            send_request(OP_PUSH, 32'h0000_1000 + k);
        end
        send_request(OP_PUSH, 32'h5555_aaaa);
        send_request(OP_SEARCH, 32'h0000_100c);
        send_request(OP_CLEAR, 32'haaaa_5555);
        wait_drained();

        run_random(100);
        wait_drained();

        send_idle_pct = 74;
        fork
            hold_receiver(300);
            run_random(100);
        join
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 74;
        run_random(100);
        wait_drained();

        send_idle_pct  = 9;
        recv_stall_pct = 9;
        run_random(100);

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[fifo_queue_with_key_search_top] OK");
        end
        else
        begin
            $display("[fifo_queue_with_key_search_top] ERROR");
        end
        $finish;
    end

endmodule
